@@ rtl/interp_to_bezier_patch_top_defines.svh @@
// Assertion macros used by the top level of the Bezier patch converter.
// Each macro takes a label, the clock, the active-low reset, a condition and a
// consequence that must hold in the same cycle or in the next one.
`ifndef INTERP_TO_BEZIER_PATCH_TOP_DEFINES_SVH
`define INTERP_TO_BEZIER_PATCH_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define IBP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define IBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define IBP_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define IBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ibp_pkg.sv @@
`timescale 1ns / 1ps

package ibp_pkg;

	// Default coordinate width and fixed result width.
	localparam int COORD_WIDTH = 16;
	localparam int OUT_W = 22;

	// Patch geometry: 16 points, 4-bit point index, 6-bit point/tap sequence.
	localparam int NUM_PTS = 16;
	localparam int IDX_W = 4;
	localparam int SEQ_W = 6;
	localparam int LANES = 3;

	// Growth of the sums: 34 * |v| per pass, 1156 * |v| after both passes.
	localparam int ROW_GROWTH = 6;
	localparam int COL_GROWTH = 12;

	// Rounding bias for the division by 36.
	localparam int ROUND_BIAS = 18;

	localparam int COEF_W = 6;
	typedef logic signed [COEF_W-1:0] coef_t;

	// Six times the interpolating-to-Bezier matrix.
	localparam coef_t MAT6 [4][4] = '{
		'{ 6'sd6,   6'sd0,   6'sd0,   6'sd0},
		'{-6'sd5,   6'sd18, -6'sd9,   6'sd2},
		'{ 6'sd2,  -6'sd9,   6'sd18, -6'sd5},
		'{ 6'sd0,   6'sd0,   6'sd0,   6'sd6}
	};

	// Saturation limits of a control point coordinate.
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROW,
		ST_COL,
		ST_CWAIT
	} state_t;

endpackage

@@ rtl/ibp_ram.sv @@
`timescale 1ns / 1ps

module ibp_ram #(
	parameter int WIDTH = ibp_pkg::LANES * ibp_pkg::COORD_WIDTH,
	parameter int DEPTH = ibp_pkg::NUM_PTS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/interp_to_bezier_patch_top.sv @@
`timescale 1ns / 1ps
// Interpolating-to-Bezier bicubic patch converter.
// Sample channel (sample_valid, sample_stall, coord_x/y/z): 16 points of a 4x4
// patch in row-major order, signed Q8.8, at most one transfer per cycle.
// Point channel (point_valid, point_stall, out_x/y/z, point_row, point_col,
// last_point): 16 control points in row-major order; last_point marks the
// sixteenth. Each is divided by 36, rounded half away from zero, saturated.
// After the 16th sample the row pass reads the sample memory through its single
// read port, one read per cycle. Each control point then takes four reads of
// the partial-sum memory, accumulate, a reciprocal multiply and a correction.
// The first 15 samples of the next patch can load during the column pass.
// sample_stall is high during the row pass and, in the column pass, once 15
// samples of the next patch are held. While point_stall is high the result
// stays on the port and the column pass waits behind it.
// Reset clears the sequencer, the load count and all valid flags; a partly
// loaded patch is dropped and loading restarts at the first point.
`include "interp_to_bezier_patch_top_defines.svh"

module interp_to_bezier_patch_top #(
	parameter int COORD_WIDTH = ibp_pkg::COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic signed [COORD_WIDTH-1:0] coord_z,
	output logic                          point_valid,
	input  logic                          point_stall,
	output logic signed [ibp_pkg::OUT_W-1:0] out_x,
	output logic signed [ibp_pkg::OUT_W-1:0] out_y,
	output logic signed [ibp_pkg::OUT_W-1:0] out_z,
	output logic [1:0]                    point_row,
	output logic [1:0]                    point_col,
	output logic                          last_point
);

	localparam int CW = COORD_WIDTH;
	localparam int LN = ibp_pkg::LANES;
	localparam int OW = ibp_pkg::OUT_W;
	localparam int PW = CW + ibp_pkg::ROW_GROWTH;
	localparam int SW = CW + ibp_pkg::COL_GROWTH;
	localparam int XW = SW - 2;
	localparam int EW = (XW > OW) ? XW + 1 : OW + 1;
	localparam int IW = ibp_pkg::IDX_W;
	localparam logic [XW-1:0] RCP = XW'((64'd1 << XW) / 64'd9);
	localparam logic [XW-1:0] NINE = XW'(9);
	localparam logic [EW-1:0] NEG_LIM = EW'(64'd1 << (OW - 1));
	localparam logic [EW-1:0] POS_LIM = NEG_LIM - EW'(1);
	localparam logic [IW-1:0] LAST_IDX = IW'(ibp_pkg::NUM_PTS - 1);

	ibp_pkg::state_t state_q, state_d;
	logic [ibp_pkg::SEQ_W-1:0] cnt_q;
	logic [IW-1:0] load_cnt_q;
	logic issue, col_issue, load_open;
	logic smp_acc;

	logic [LN*CW-1:0] smp_wdata, smp_rdata;
	logic [LN*PW-1:0] part_wdata, part_rdata;
	logic [IW-1:0] smp_raddr, part_raddr;
	logic part_we;

	logic vld_s1, col_s1;
	logic [IW-1:0] n_s1;
	logic [1:0] k_s1;
	ibp_pkg::coef_t coef_s1;
	logic signed [SW-1:0] opnd [LN];
	logic signed [SW-1:0] prod [LN];
	logic signed [SW-1:0] acc_d [LN];
	logic signed [SW-1:0] acc_q [LN];

	logic vld_s2;
	logic [IW-1:0] n_s2;
	logic [SW-1:0] mag [LN];
	logic [SW-1:0] biased [LN];
	logic [XW-1:0] x2 [LN];
	logic [2*XW-1:0] mul2 [LN];

	logic vld_s3;
	logic [IW-1:0] n_s3;
	logic [XW-1:0] q0_s3 [LN];
	logic [XW-1:0] x_s3 [LN];
	logic neg_s3 [LN];
	logic [XW-1:0] rem3 [LN];
	logic [XW-1:0] qf3 [LN];
	logic [EW-1:0] qe3 [LN];
	logic [EW-1:0] qn3 [LN];
	logic signed [OW-1:0] res3 [LN];
	logic last_s3;

	logic out_vld_q, out_free, res_mv;
	logic signed [OW-1:0] out_x_q, out_y_q, out_z_q;
	logic [1:0] row_q, col_q;
	logic last_q;

	// Sample channel transfer.
	assign sample_stall = !load_open;
	assign smp_acc = sample_valid && !sample_stall;

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ibp_pkg::ST_LOAD: begin
				if (smp_acc && load_cnt_q == LAST_IDX) begin
					state_d = ibp_pkg::ST_ROW;
				end
			end
			ibp_pkg::ST_ROW: begin
				if (cnt_q == '1) begin
					state_d = ibp_pkg::ST_COL;
				end
			end
			ibp_pkg::ST_COL: begin
				if (cnt_q[1:0] == 2'b11) begin
					state_d = ibp_pkg::ST_CWAIT;
				end
			end
			ibp_pkg::ST_CWAIT: begin
				if (res_mv) begin
					state_d = last_s3 ? ibp_pkg::ST_LOAD : ibp_pkg::ST_COL;
				end
			end
			default: state_d = ibp_pkg::ST_LOAD;
		endcase
	end

	// Sequencer outputs: memory reads and whether samples may load.
	always_comb begin
		issue = 1'b0;
		col_issue = 1'b0;
		load_open = 1'b0;
		unique case (state_q)
			ibp_pkg::ST_LOAD: load_open = 1'b1;
			ibp_pkg::ST_ROW: issue = 1'b1;
			ibp_pkg::ST_COL: begin
				issue = 1'b1;
				col_issue = 1'b1;
				load_open = (load_cnt_q != LAST_IDX);
			end
			ibp_pkg::ST_CWAIT: load_open = (load_cnt_q != LAST_IDX);
			default: load_open = 1'b0;
		endcase
	end

	// Sequencer, load counter and pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ibp_pkg::ST_LOAD;
			cnt_q <= '0;
			load_cnt_q <= '0;
			vld_s1 <= 1'b0;
			col_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (smp_acc) begin
				load_cnt_q <= load_cnt_q + 1'b1;
			end
			vld_s1 <= issue;
			col_s1 <= col_issue;
			vld_s2 <= vld_s1 && col_s1 && (k_s1 == 2'b11);
			if (vld_s2) begin
				vld_s3 <= 1'b1;
			end else if (res_mv) begin
				vld_s3 <= 1'b0;
			end
		end
	end

	// Sample memory: written by the sample channel, read in the row pass.
	assign smp_wdata = {coord_z, coord_y, coord_x};
	assign smp_raddr = {cnt_q[1:0], cnt_q[3:2]};

	ibp_ram #(
		.WIDTH(LN * CW),
		.DEPTH(ibp_pkg::NUM_PTS)
	) u_smp_ram (
		.clk(clk),
		.we(smp_acc),
		.waddr(load_cnt_q),
		.wdata(smp_wdata),
		.raddr(smp_raddr),
		.rdata(smp_rdata)
	);

	// Partial-sum memory: written at the end of each row sum, read per point.
	assign part_raddr = {cnt_q[5:4], cnt_q[1:0]};
	assign part_we = vld_s1 && !col_s1 && (k_s1 == 2'b11);

	ibp_ram #(
		.WIDTH(LN * PW),
		.DEPTH(ibp_pkg::NUM_PTS)
	) u_part_ram (
		.clk(clk),
		.we(part_we),
		.waddr(n_s1),
		.wdata(part_wdata),
		.raddr(part_raddr),
		.rdata(part_rdata)
	);

	// Read stage tags: target point and tap of the data coming out of memory.
	always_ff @(posedge clk) begin
		n_s1 <= cnt_q[5:2];
		k_s1 <= cnt_q[1:0];
	end

	// Multiply-accumulate over four taps, one per cycle, for all lanes.
	always_comb begin
		coef_s1 = col_s1 ? ibp_pkg::MAT6[n_s1[1:0]][k_s1] : ibp_pkg::MAT6[n_s1[3:2]][k_s1];
		part_wdata = '0;
		for (int d = 0; d < LN; d++) begin
			opnd[d] = col_s1 ? SW'($signed(part_rdata[d*PW +: PW]))
				: SW'($signed(smp_rdata[d*CW +: CW]));
			prod[d] = opnd[d] * SW'(coef_s1);
			acc_d[d] = (k_s1 == 2'b00) ? prod[d] : acc_q[d] + prod[d];
			part_wdata[d*PW +: PW] = acc_d[d][PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			for (int d = 0; d < LN; d++) begin
				acc_q[d] <= acc_d[d];
			end
		end
		n_s2 <= n_s1;
	end

	// Rounding: magnitude plus 18, then a quarter of it times the reciprocal of 9.
	always_comb begin
		for (int d = 0; d < LN; d++) begin
			mag[d] = acc_q[d][SW-1] ? $unsigned(-acc_q[d]) : $unsigned(acc_q[d]);
			biased[d] = mag[d] + SW'(ibp_pkg::ROUND_BIAS);
			x2[d] = biased[d][SW-1:2];
			mul2[d] = {{XW{1'b0}}, x2[d]} * {{XW{1'b0}}, RCP};
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			n_s3 <= n_s2;
			for (int d = 0; d < LN; d++) begin
				q0_s3[d] <= mul2[d][XW +: XW];
				x_s3[d] <= x2[d];
				neg_s3[d] <= acc_q[d][SW-1];
			end
		end
	end

	// The estimate is low by at most one: correct it, restore the sign, saturate.
	always_comb begin
		for (int d = 0; d < LN; d++) begin
			rem3[d] = x_s3[d] - (q0_s3[d] << 3) - q0_s3[d];
			qf3[d] = (rem3[d] >= NINE) ? q0_s3[d] + 1'b1 : q0_s3[d];
			qe3[d] = EW'(qf3[d]);
			qn3[d] = -qe3[d];
			if (neg_s3[d]) begin
				res3[d] = (qe3[d] > NEG_LIM) ? ibp_pkg::OUT_MIN : $signed(qn3[d][OW-1:0]);
			end else begin
				res3[d] = (qe3[d] > POS_LIM) ? ibp_pkg::OUT_MAX : $signed(qe3[d][OW-1:0]);
			end
		end
	end

	assign last_s3 = (n_s3 == LAST_IDX);

	// Output register: takes a result whenever the previous transfer is done.
	assign out_free = !out_vld_q || !point_stall;
	assign res_mv = vld_s3 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_mv) begin
			out_vld_q <= 1'b1;
		end else if (!point_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_mv) begin
			out_x_q <= res3[0];
			out_y_q <= res3[1];
			out_z_q <= res3[2];
			row_q <= n_s3[3:2];
			col_q <= n_s3[1:0];
			last_q <= last_s3;
		end
	end

	assign point_valid = out_vld_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_z = out_z_q;
	assign point_row = row_q;
	assign point_col = col_q;
	assign last_point = last_q;

	// The row pass starts right after the sixteenth sample.
	`IBP_ASSERT_NEXT(a_row_after_last_sample, clk, arst_n, state_q == ibp_pkg::ST_LOAD && smp_acc && load_cnt_q == LAST_IDX, state_q == ibp_pkg::ST_ROW)
	// No sample is written while the row pass reads the sample memory.
	`IBP_ASSERT_SAME(a_no_load_in_row, clk, arst_n, state_q == ibp_pkg::ST_ROW, !smp_acc)
	// A point's reads start only after the previous point has left the pipeline.
	`IBP_ASSERT_SAME(a_col_issue_clear, clk, arst_n, state_q == ibp_pkg::ST_COL, !vld_s2 && !vld_s3)
	// A pending result only exists while the sequencer waits for it.
	`IBP_ASSERT_SAME(a_s3_in_wait, clk, arst_n, vld_s3, state_q == ibp_pkg::ST_CWAIT)
	// Handing over the last control point returns the sequencer to loading.
	`IBP_ASSERT_NEXT(a_last_to_load, clk, arst_n, res_mv && last_s3, state_q == ibp_pkg::ST_LOAD)

endmodule
